>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define COSU_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define COSU_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/cosu_pkg.sv
// Package for the cosine similarity unit: widths, defaults, queue entry type,
// back-end state type and the accumulator limit function. No dependencies.
`timescale 1ns / 1ps

package cosu_pkg;

  localparam int DEF_MAX_LEN   = 4096;
  localparam int DEF_ELEM_BITS = 16;

  localparam int IN_W    = 16;
  localparam int COS_W   = 16;
  localparam int ACC_W   = 48;
  localparam int MAG_W   = ACC_W - 1;
  localparam int FRAC_SH = 32;
  localparam int DIV_BITS = MAG_W + FRAC_SH;
  localparam int CNT_W   = $clog2(DIV_BITS);
  localparam int ROOT_STEPS = 32;
  localparam int ROOT_W  = 64;
  localparam int Q_BITS  = 20;

  localparam int Q_DEPTH = 2;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic signed [ACC_W-1:0] dot;
    logic signed [ACC_W-1:0] norm_a;
    logic signed [ACC_W-1:0] norm_b;
  } cosu_entry_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_ROOT,
    B_MUL,
    B_DIV,
    B_DONE
  } back_state_t;

  // Smaller of max_len * 2^(2*elem_bits-2) and 2^(ACC_W-1)-1.
  function automatic logic [ACC_W-1:0] acc_limit(input int max_len, input int elem_bits);
    logic [63:0] cap;
    logic [63:0] lim;
    cap = (64'd1 << (ACC_W - 1)) - 64'd1;
    lim = 64'(max_len) << (2 * elem_bits - 2);
    return (lim < cap) ? lim[ACC_W-1:0] : cap[ACC_W-1:0];
  endfunction

endpackage

>>> rtl/cosu_if.sv
// Channel interfaces of the cosine similarity unit: element pairs in, results out.
// Depends on cosu_pkg.
`timescale 1ns / 1ps

interface cosu_in_if import cosu_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic signed [IN_W-1:0] elem_a;
  logic signed [IN_W-1:0] elem_b;
  logic                   last;

  modport source (output valid, output elem_a, output elem_b, output last, input ready);
  modport sink   (input valid, input elem_a, input elem_b, input last, output ready);
endinterface

interface cosu_out_if import cosu_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [COS_W-1:0] cosine;
  logic                    zero_norm;

  modport source (output valid, output cosine, output zero_norm, input ready);
  modport sink   (input valid, input cosine, input zero_norm, output ready);
endinterface

>>> rtl/cosu_mac.sv
// Front end: registered multiplies and saturating accumulation, one pair per cycle; the last
// pair pushes the three sums, stalling while the queue is full. Depends on cosu_pkg, cosu_if.
`timescale 1ns / 1ps

module cosu_mac import cosu_pkg::*; #(
  parameter int MAX_LEN   = DEF_MAX_LEN,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic        clk,
  input  logic        rst,
  cosu_in_if.sink     samples,
  output logic        push,
  output cosu_entry_t push_data,
  input  logic        q_full
);

  localparam int PW = 2 * ELEM_BITS;
  localparam logic [ACC_W-1:0] LIM = acc_limit(MAX_LEN, ELEM_BITS);
  localparam logic signed [ACC_W:0] LIM_P = {1'b0, LIM};
  localparam logic signed [ACC_W:0] LIM_N = -LIM_P;

  logic signed [ELEM_BITS-1:0] ea;
  logic signed [ELEM_BITS-1:0] eb;

  if (ELEM_BITS <= IN_W) begin : g_trim
    assign ea = samples.elem_a[ELEM_BITS-1:0];
    assign eb = samples.elem_b[ELEM_BITS-1:0];
  end else begin : g_ext
    assign ea = {{(ELEM_BITS-IN_W){1'b0}}, samples.elem_a};
    assign eb = {{(ELEM_BITS-IN_W){1'b0}}, samples.elem_b};
  end

  logic                 s1_valid;
  logic                 s1_last;
  logic signed [PW-1:0] pab;
  logic signed [PW-1:0] paa;
  logic signed [PW-1:0] pbb;
  logic                 s1_adv;
  logic                 take;

  logic signed [ACC_W-1:0] dot_acc;
  logic signed [ACC_W-1:0] norm_a_acc;
  logic signed [ACC_W-1:0] norm_b_acc;
  logic signed [ACC_W-1:0] dot_next;
  logic signed [ACC_W-1:0] norm_a_next;
  logic signed [ACC_W-1:0] norm_b_next;

  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] acc,
                                                      input logic signed [PW-1:0] term);
    logic signed [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W+1-PW){term[PW-1]}}, term};
    if (s > LIM_P) begin
      s = LIM_P;
    end else if (s < LIM_N) begin
      s = LIM_N;
    end
    return s[ACC_W-1:0];
  endfunction

  assign s1_adv        = s1_valid && (!s1_last || !q_full);
  assign samples.ready = !s1_valid || !s1_last || !q_full;
  assign take          = samples.valid && samples.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_last <= samples.last;
      pab     <= PW'(ea) * PW'(eb);
      paa     <= PW'(ea) * PW'(ea);
      pbb     <= PW'(eb) * PW'(eb);
    end
  end

  always_comb begin
    dot_next    = sat_add(dot_acc, pab);
    norm_a_next = sat_add(norm_a_acc, paa);
    norm_b_next = sat_add(norm_b_acc, pbb);
  end

  assign push             = s1_valid && s1_last && !q_full;
  assign push_data.dot    = dot_next;
  assign push_data.norm_a = norm_a_next;
  assign push_data.norm_b = norm_b_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      dot_acc    <= '0;
      norm_a_acc <= '0;
      norm_b_acc <= '0;
    end else if (s1_adv) begin
      if (s1_last) begin
        dot_acc    <= '0;
        norm_a_acc <= '0;
        norm_b_acc <= '0;
      end else begin
        dot_acc    <= dot_next;
        norm_a_acc <= norm_a_next;
        norm_b_acc <= norm_b_next;
      end
    end
  end

endmodule

>>> rtl/cosu_queue.sv
// Short queue of finished sum triples between the front end and the back end.
// Depends on cosu_pkg.
`timescale 1ns / 1ps

module cosu_queue import cosu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cosu_entry_t push_data,
  output logic        full,
  input  logic        pop,
  output cosu_entry_t pop_data,
  output logic        not_empty
);

  cosu_entry_t             slots [Q_DEPTH];
  logic [Q_PTR_W-1:0]      wr_ptr;
  logic [Q_PTR_W-1:0]      rd_ptr;
  logic [Q_CNT_W-1:0]      count;
  logic                    do_push;
  logic                    do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/cosu_back.sv
// Back end: bit-serial square roots of both norms, one multiply, then a restoring
// divide one quotient bit per cycle; rounds, saturates and holds the result. Depends on cosu_pkg, cosu_if.
`timescale 1ns / 1ps

module cosu_back import cosu_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  cosu_entry_t q_data,
  output logic        pop,
  cosu_out_if.source  results
);

  localparam logic [Q_BITS:0]  Q_CAP   = {1'b1, {Q_BITS{1'b0}}};
  localparam logic [Q_BITS:0]  NEG_MAX = (Q_BITS + 1)'(1 << (COS_W - 1));
  localparam logic [Q_BITS:0]  POS_MAX = (Q_BITS + 1)'((1 << (COS_W - 1)) - 1);

  back_state_t st, st_next;

  logic [CNT_W-1:0]    cnt;
  logic                zflag;
  logic                dot_neg;
  logic [MAG_W-1:0]    mag;
  logic [ROOT_W-1:0]   xa, xb, ra, rb, bitm;
  logic [ROOT_W-1:0]   ta, tb;
  logic                ge_a, ge_b;
  logic [ROOT_W-1:0]   dv;
  logic [ROOT_W-1:0]   rem;
  logic [ROOT_W:0]     rs;
  logic                qb;
  logic [DIV_BITS-1:0] nsh;
  logic [Q_BITS-1:0]   qv;
  logic                big;
  logic                is_zero;
  logic [ACC_W-1:0]    dot_abs;
  logic                out_free;

  logic [Q_BITS:0]     qfull_v;
  logic [Q_BITS:0]     rnd;
  logic [Q_BITS:0]     rc;
  logic [COS_W-1:0]    cos_calc;

  logic                out_valid;
  logic [COS_W-1:0]    out_cos;
  logic                out_zn;

  assign out_free = !out_valid || results.ready;
  assign is_zero  = (q_data.norm_a == '0) || (q_data.norm_b == '0);
  assign dot_abs  = q_data.dot[ACC_W-1] ? -q_data.dot : q_data.dot;

  assign ta   = ra + bitm;
  assign tb   = rb + bitm;
  assign ge_a = (xa >= ta);
  assign ge_b = (xb >= tb);

  assign rs = {rem, nsh[DIV_BITS-1]};
  assign qb = (rs >= {1'b0, dv});

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= B_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next = st;
    pop     = 1'b0;
    case (st)
      B_IDLE: begin
        if (q_valid) begin
          pop     = 1'b1;
          st_next = is_zero ? B_DONE : B_ROOT;
        end
      end
      B_ROOT: begin
        if (cnt == '0) st_next = B_MUL;
      end
      B_MUL: begin
        st_next = B_DIV;
      end
      B_DIV: begin
        if (cnt == '0) st_next = B_DONE;
      end
      B_DONE: begin
        if (out_free) st_next = B_IDLE;
      end
      default: st_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st)
      B_IDLE: begin
        if (q_valid) begin
          zflag   <= is_zero;
          dot_neg <= q_data.dot[ACC_W-1];
          mag     <= dot_abs[MAG_W-1:0];
          xa      <= {1'b0, q_data.norm_a[MAG_W-1:0], 16'd0};
          xb      <= {1'b0, q_data.norm_b[MAG_W-1:0], 16'd0};
          ra      <= '0;
          rb      <= '0;
          bitm    <= ROOT_W'(1) << (2 * ROOT_STEPS - 2);
          cnt     <= CNT_W'(ROOT_STEPS - 1);
        end
      end
      B_ROOT: begin
        xa   <= ge_a ? xa - ta : xa;
        xb   <= ge_b ? xb - tb : xb;
        ra   <= ge_a ? (ra >> 1) + bitm : ra >> 1;
        rb   <= ge_b ? (rb >> 1) + bitm : rb >> 1;
        bitm <= bitm >> 2;
        cnt  <= cnt - 1'b1;
      end
      B_MUL: begin
        dv  <= ROOT_W'(ra[ROOT_W/2-1:0]) * ROOT_W'(rb[ROOT_W/2-1:0]);
        nsh <= {mag, {FRAC_SH{1'b0}}};
        rem <= '0;
        qv  <= '0;
        big <= 1'b0;
        cnt <= CNT_W'(DIV_BITS - 1);
      end
      B_DIV: begin
        rem <= qb ? ROOT_W'(rs - {1'b0, dv}) : rs[ROOT_W-1:0];
        qv  <= {qv[Q_BITS-2:0], qb};
        big <= big || (qb && (cnt >= CNT_W'(Q_BITS)));
        nsh <= nsh << 1;
        cnt <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    qfull_v = big ? Q_CAP : {1'b0, qv};
    rnd     = (qfull_v + 1'b1) >> 1;
    if (dot_neg) begin
      rc       = (rnd > NEG_MAX) ? NEG_MAX : rnd;
      cos_calc = COS_W'(~rc + 1'b1);
    end else begin
      rc       = (rnd > POS_MAX) ? POS_MAX : rnd;
      cos_calc = rc[COS_W-1:0];
    end
    if (zflag) begin
      cos_calc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == B_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == B_DONE && out_free) begin
      out_cos <= cos_calc;
      out_zn  <= zflag;
    end
  end

  assign results.valid     = out_valid;
  assign results.cosine    = out_cos;
  assign results.zero_norm = out_zn;

endmodule

>>> rtl/cosine_similarity_unit.sv
// Cosine similarity of two streamed Q1.15 vectors, one element pair per transaction,
// result as saturated Q1.15 with a zero-norm flag. Element pairs are taken at one per
// cycle; a pair's products are registered before they reach the accumulators. Each
// vector's result then passes through the back end as a queue pop, 32 root steps, a
// multiply, 79 divide steps and an output load; a vector with a zero norm skips the
// root and divide. Two finished vectors can wait in the queue; a last pair stalls when
// it is full. Depends on cosu_pkg, cosu_if, cosu_mac, cosu_queue, cosu_back.
`timescale 1ns / 1ps

module cosine_similarity_unit import cosu_pkg::*; #(
  parameter int MAX_LEN   = DEF_MAX_LEN,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic       clk,
  input  logic       rst,
  cosu_in_if.sink    samples,
  cosu_out_if.source results
);

  logic        push;
  cosu_entry_t push_data;
  logic        q_full;
  logic        pop;
  cosu_entry_t pop_data;
  logic        q_valid;

  cosu_mac #(
    .MAX_LEN   (MAX_LEN),
    .ELEM_BITS (ELEM_BITS)
  ) u_mac (
    .clk       (clk),
    .rst       (rst),
    .samples   (samples),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  cosu_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .pop_data  (pop_data),
    .not_empty (q_valid)
  );

  cosu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (pop_data),
    .pop     (pop),
    .results (results)
  );

endmodule

>>> rtl/cosu_checker.sv
// Port-level checks for the cosine similarity unit, bound to the top level.
// Depends on cosu_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cosu_checker import cosu_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [COS_W-1:0] cosine,
  input logic                    zero_norm
);

  `COSU_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")
  `COSU_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(cosine) && $stable(zero_norm), "stalled result changed")
  `COSU_ASSERT_IMP(a_zero_cos, out_valid && zero_norm, cosine == '0, "zero norm with nonzero cosine")
  `COSU_ASSERT_IMP(a_reset_quiet, $past(rst), !out_valid, "result shown straight after reset")

endmodule

bind cosine_similarity_unit cosu_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .cosine    (results.cosine),
  .zero_norm (results.zero_norm)
);

>>> tb/cosine_similarity_unit_checker.sv
// Checker for the cosine similarity unit: watches both channels, predicts each result
// from the accepted element pairs and compares it field by field.
// Depends on cosu_pkg and cosu_if.
`timescale 1ns / 1ps

module cosine_similarity_unit_checker import cosu_pkg::*; #(
  parameter int MAX_LEN   = DEF_MAX_LEN,
  parameter int ELEM_BITS = DEF_ELEM_BITS
) (
  input  logic clk,
  input  logic rst,
  cosu_in_if   samples,
  cosu_out_if  results,
  output int   fail_count,
  output int   pending,
  output int   results_seen,
  output int   zero_norms,
  output int   clipped
);

  typedef struct packed {
    logic signed [COS_W-1:0] cosine;
    logic                    zero_norm;
  } cos_result_t;

  localparam longint unsigned SUM_CAP = (64'd1 << (ACC_W - 1)) - 64'd1;
  localparam longint unsigned SUM_RAW = 64'(MAX_LEN) << (2 * ELEM_BITS - 2);
  localparam longint SUM_LIM = (SUM_RAW < SUM_CAP) ? SUM_RAW : SUM_CAP;
  localparam longint unsigned Q_CAP = 64'd1 << 20;

  cos_result_t expected_cosines[$];
  cos_result_t want;
  longint      dot_sum;
  longint      energy_a;
  longint      energy_b;
  longint      pair_a;
  longint      pair_b;

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= 100)
      $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic longint elem_of(logic [IN_W-1:0] raw);
    longint unsigned v;
    v = 64'(raw) & ((64'd1 << ELEM_BITS) - 64'd1);
    if (v[ELEM_BITS-1])
      return longint'(v) - (longint'(1) << ELEM_BITS);
    return longint'(v);
  endfunction

  function automatic longint clamp_sum(longint acc, longint term);
    longint s;
    s = acc + term;
    if (s > SUM_LIM)
      s = SUM_LIM;
    if (s < -SUM_LIM)
      s = -SUM_LIM;
    return s;
  endfunction

  function automatic longint unsigned root_floor(longint unsigned x);
    longint unsigned r;
    longint unsigned trial;
    r = 0;
    for (int i = 31; i >= 0; i--) begin
      trial = r | (64'd1 << i);
      if (trial * trial <= x)
        r = trial;
    end
    return r;
  endfunction

  // dot / (|a| * |b|) with roots carrying 8 extra fraction bits, rounded half away
  function automatic cos_result_t cosine_of_sums(longint dot, longint na, longint nb);
    cos_result_t     res;
    longint unsigned sa;
    longint unsigned sb;
    longint unsigned mag;
    longint unsigned q;
    longint unsigned r;
    logic [127:0]    quot;
    res = '0;
    if (na == 0 || nb == 0) begin
      res.zero_norm = 1'b1;
      return res;
    end
    sa = root_floor(64'(na) << 16);
    sb = root_floor(64'(nb) << 16);
    mag = (dot < 0) ? 64'(-dot) : 64'(dot);
    quot = ({64'd0, mag} << 32) / {64'd0, sa * sb};
    q = (quot >= 128'(Q_CAP)) ? Q_CAP : quot[63:0];
    r = (q + 64'd1) >> 1;
    if (dot < 0) begin
      if (r > 64'd32768)
        r = 64'd32768;
      res.cosine = COS_W'(64'd0 - r);
    end else begin
      if (r > 64'd32767)
        r = 64'd32767;
      res.cosine = COS_W'(r);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      dot_sum = 0;
      energy_a = 0;
      energy_b = 0;
      expected_cosines.delete();
    end else begin
      if (samples.valid && samples.ready) begin
        pair_a = elem_of(samples.elem_a);
        pair_b = elem_of(samples.elem_b);
        dot_sum = clamp_sum(dot_sum, pair_a * pair_b);
        energy_a = clamp_sum(energy_a, pair_a * pair_a);
        energy_b = clamp_sum(energy_b, pair_b * pair_b);
        if (samples.last) begin
          expected_cosines.push_back(cosine_of_sums(dot_sum, energy_a, energy_b));
          dot_sum = 0;
          energy_a = 0;
          energy_b = 0;
        end
      end
      if (results.valid && results.ready) begin
        if (expected_cosines.size() == 0) begin
          report_mismatch($sformatf("result with none expected: cosine=%0d zero_norm=%0b",
                                    results.cosine, results.zero_norm));
        end else begin
          want = expected_cosines.pop_front();
          results_seen++;
          if (results.cosine !== want.cosine)
            report_mismatch($sformatf("result %0d cosine: got %0d, expected %0d",
                                      results_seen, results.cosine, want.cosine));
          if (results.zero_norm !== want.zero_norm)
            report_mismatch($sformatf("result %0d zero_norm: got %0b, expected %0b",
                                      results_seen, results.zero_norm, want.zero_norm));
          if (want.zero_norm)
            zero_norms++;
          if (want.cosine == 16'sh7FFF || want.cosine == 16'sh8000)
            clipped++;
        end
      end
    end
    pending = expected_cosines.size();
  end

endmodule

>>> tb/cosine_similarity_unit_tb.sv
// Testbench top for the cosine similarity unit: clock, reset, element pair stimulus,
// result back-pressure and the verdict. Depends on cosu_pkg, cosu_if, the unit and
// cosine_similarity_unit_checker.
`timescale 1ns / 1ps

module cosine_similarity_unit_tb;
  import cosu_pkg::*;

  typedef enum int {
    VEC_RANDOM,
    VEC_SMALL,
    VEC_SAME,
    VEC_OPPOSITE,
    VEC_NEAR,
    VEC_ZERO_A,
    VEC_ZERO_B,
    VEC_RAILS
  } vec_kind_t;

  localparam int TB_MAX_LEN   = 64;
  localparam int RANDOM_PAIRS = 350;
  localparam int PRESSURE_AT  = 20;
  localparam int PRESSURE_LEN = 1500;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int TAIL_CYCLES  = 200;

  logic clk;
  logic rst;
  int   pairs_sent;
  int   send_calm;
  int   recv_calm;
  int   recv_count;
  int   chk_failures;
  int   chk_pending;
  int   chk_results;
  int   chk_zero_norms;
  int   chk_clipped;

  cosu_in_if  samples_if ();
  cosu_out_if results_if ();

  cosine_similarity_unit #(
    .MAX_LEN (TB_MAX_LEN)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .samples (samples_if),
    .results (results_if)
  );

  cosine_similarity_unit_checker #(
    .MAX_LEN (TB_MAX_LEN)
  ) checker_i (
    .clk          (clk),
    .rst          (rst),
    .samples      (samples_if),
    .results      (results_if),
    .fail_count   (chk_failures),
    .pending      (chk_pending),
    .results_seen (chk_results),
    .zero_norms   (chk_zero_norms),
    .clipped      (chk_clipped)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Idle cycles before the next transaction, with occasional runs of none.
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 29) == 0)
      calm = $urandom_range(10, 60);
    return $urandom_range(0, 19);
  endfunction

  // Call just after a rising edge; returns just after the edge that takes the pair.
  task automatic put_pair(logic [IN_W-1:0] a, logic [IN_W-1:0] b, logic is_last);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      samples_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    samples_if.valid  <= 1'b1;
    samples_if.elem_a <= a;
    samples_if.elem_b <= b;
    samples_if.last   <= is_last;
    @(posedge clk);
    while (!samples_if.ready)
      @(posedge clk);
    pairs_sent++;
  endtask

  function automatic logic [IN_W-1:0] rail_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h8001;
      2: return 16'hFFFF;
      3: return 16'h0000;
      4: return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  task automatic send_vector(vec_kind_t kind, int len);
    logic [IN_W-1:0] a;
    logic [IN_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      a = IN_W'($urandom);
      b = IN_W'($urandom);
      case (kind)
        VEC_SMALL: begin
          a = IN_W'($urandom_range(0, 64) - 32);
          b = IN_W'($urandom_range(0, 64) - 32);
        end
        VEC_SAME:     b = a;
        VEC_OPPOSITE: b = -a;
        VEC_NEAR:     b = a + IN_W'($urandom_range(0, 512) - 256);
        VEC_ZERO_A:   a = '0;
        VEC_ZERO_B:   b = '0;
        VEC_RAILS: begin
          a = rail_value();
          b = rail_value();
        end
        default: ;
      endcase
      put_pair(a, b, i == len - 1);
    end
  endtask

  initial begin
    int waited;
    int rand_start;
    rst <= 1'b1;
    samples_if.valid  <= 1'b0;
    samples_if.elem_a <= '0;
    samples_if.elem_b <= '0;
    samples_if.last   <= 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single pairs at the rails, zero norms, orthogonal and short vectors
    put_pair(16'h7FFF, 16'h7FFF, 1'b1);
    put_pair(16'h8000, 16'h8000, 1'b1);
    put_pair(16'h8000, 16'h7FFF, 1'b1);
    put_pair(16'h7FFF, 16'h8000, 1'b1);
    put_pair(16'h0000, 16'h0000, 1'b1);
    put_pair(16'h0000, 16'h0005, 1'b1);
    put_pair(16'hFFFB, 16'h0000, 1'b1);
    put_pair(16'h0001, 16'h0001, 1'b1);
    put_pair(16'h0001, 16'hFFFF, 1'b1);
    put_pair(16'hFFFF, 16'h8000, 1'b1);
    put_pair(16'h03E8, 16'h0000, 1'b0);
    put_pair(16'h0000, 16'h03E8, 1'b1);
    put_pair(16'h0000, 16'h0000, 1'b0);
    put_pair(16'h0000, 16'h0000, 1'b0);
    put_pair(16'h0064, 16'hFF9C, 1'b1);
    put_pair(16'h1234, 16'h0F00, 1'b0);
    put_pair(16'hEDCC, 16'h7000, 1'b0);
    put_pair(16'h0400, 16'hFC00, 1'b1);

    // over-length vectors: all three sums hit the limit, then the dot product negative
    for (int i = 0; i < TB_MAX_LEN + 100; i++)
      put_pair(16'h8000, 16'h8000, i == TB_MAX_LEN + 99);
    for (int i = 0; i < TB_MAX_LEN + 200; i++)
      put_pair(16'h8000, 16'h7FFF, i == TB_MAX_LEN + 199);

    rand_start = pairs_sent;
    while (pairs_sent - rand_start < RANDOM_PAIRS)
      send_vector(vec_kind_t'($urandom_range(0, 7)),
                  ($urandom_range(0, 7) == 0) ? $urandom_range(17, 64) :
                                                $urandom_range(1, 16));
    samples_if.valid <= 1'b0;

    waited = 0;
    @(negedge clk);
    while (chk_pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (TAIL_CYCLES) @(posedge clk);

    if (chk_pending != 0)
      $display("%0d expected results never arrived", chk_pending);
    $display("covered %0d pair transactions and %0d results: %0d zero-norm, %0d at a rail,",
             pairs_sent, chk_results, chk_zero_norms, chk_clipped);
    $display("including two vectors longer than the accumulator bound and one long output stall");
    if (chk_failures == 0 && chk_pending == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // result side: random stalls, plus one long hold-off to fill the queue
  initial begin
    int gap;
    results_if.ready <= 1'b0;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      gap = (recv_count == PRESSURE_AT) ? PRESSURE_LEN : draw_wait(recv_calm);
      if (gap > 0) begin
        results_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      results_if.ready <= 1'b1;
      @(posedge clk);
      while (!results_if.valid)
        @(posedge clk);
      recv_count++;
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
